@@ sv/walr_pkg.sv @@
// walr_pkg: shared types and codes for the anti-aliased line rasteriser
// no dependencies; used by the front, back and top level
`default_nettype none

package walr_pkg;

  // operation codes on the op field
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // line classification
  typedef enum logic [2:0] {
    CASE_HORIZ = 3'd0,
    CASE_VERT  = 3'd1,
    CASE_DIAG  = 3'd2,
    CASE_YMAJ  = 3'd3,
    CASE_XMAJ  = 3'd4
  } line_case_t;

  // control part of a queued command word
  typedef struct packed {
    logic       is_start;
    line_case_t line_case;
    logic       x_neg;
  } cmd_ctrl_t;

endpackage

`default_nettype wire

@@ sv/walr_fifo.sv @@
// walr_fifo: small show-ahead queue, one or two words written per cycle
// no dependencies; used for the command queue and the result queue
`default_nettype none

module walr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             push_two,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [WIDTH-1:0] wdata_two,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty,
  output logic                  full,
  output logic                  room_two
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    n_in;

  // words written this cycle
  always_comb begin
    n_in = '0;
    if (push) begin
      n_in = push_two ? CW'(2) : CW'(1);
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
      if (push_two) begin
        mem[wptr + AW'(1)] <= wdata_two;
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_in[AW-1:0];
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
      count <= count + n_in - CW'(pop);
    end
  end

  assign rdata    = mem[rptr];
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign room_two = (count <= CW'(DEPTH - 2));

endmodule

`default_nettype wire

@@ sv/walr_front.sv @@
// walr_front: orders endpoints by y and classifies the line
// depends on walr_pkg; feeds the command queue
`default_nettype none

module walr_front #(
  parameter int COORD_BITS = 11
) (
  input  wire logic                  op,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  output walr_pkg::cmd_ctrl_t        ctrl,
  output logic      [COORD_BITS-1:0] x0,
  output logic      [COORD_BITS-1:0] y0,
  output logic      [COORD_BITS-1:0] x1,
  output logic      [COORD_BITS-1:0] y1,
  output logic      [COORD_BITS-1:0] minor,
  output logic      [COORD_BITS-1:0] major,
  output logic      [COORD_BITS-1:0] steps
);

  logic                  swap;
  logic                  x_neg;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  // order endpoints so the first has the smaller y, ties keep order
  always_comb begin
    swap  = (y_start > y_end);
    x0    = swap ? x_end   : x_start;
    y0    = swap ? y_end   : y_start;
    x1    = swap ? x_start : x_end;
    y1    = swap ? y_start : y_end;
    x_neg = (x1 < x0);
    dx    = x_neg ? (x0 - x1) : (x1 - x0);
    dy    = y1 - y0;
  end

  // pick the case, step count and division operands
  always_comb begin
    ctrl.is_start = (op == walr_pkg::OP_START);
    ctrl.x_neg    = x_neg;
    minor         = '0;
    major         = '0;
    if (dy == '0) begin
      ctrl.line_case = walr_pkg::CASE_HORIZ;
      steps          = dx;
    end else if (dx == '0) begin
      ctrl.line_case = walr_pkg::CASE_VERT;
      steps          = dy;
    end else if (dx == dy) begin
      ctrl.line_case = walr_pkg::CASE_DIAG;
      steps          = dy;
    end else if (dy > dx) begin
      ctrl.line_case = walr_pkg::CASE_YMAJ;
      steps          = dy - COORD_BITS'(1);
      minor          = dx;
      major          = dy;
    end else begin
      ctrl.line_case = walr_pkg::CASE_XMAJ;
      steps          = dx - COORD_BITS'(1);
      minor          = dy;
      major          = dx;
    end
  end

endmodule

`default_nettype wire

@@ sv/walr_back.sv @@
// walr_back: line state, bit-serial error step division and pixel stepping
// depends on walr_pkg; reads the command queue, writes the result queue
`default_nettype none

module walr_back #(
  parameter int COORD_BITS    = 11,
  parameter int FRACTION_BITS = 16,
  parameter int LEVEL_BITS    = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  input  wire walr_pkg::cmd_ctrl_t   cmd_ctrl,
  input  wire logic [COORD_BITS-1:0] cmd_x0,
  input  wire logic [COORD_BITS-1:0] cmd_y0,
  input  wire logic [COORD_BITS-1:0] cmd_x1,
  input  wire logic [COORD_BITS-1:0] cmd_y1,
  input  wire logic [COORD_BITS-1:0] cmd_minor,
  input  wire logic [COORD_BITS-1:0] cmd_major,
  input  wire logic [COORD_BITS-1:0] cmd_steps,
  output logic                       cmd_pop,
  input  wire logic                  out_room_two,
  output logic                       out_push,
  output logic                       out_push_two,
  output logic [(2*COORD_BITS+LEVEL_BITS+4)-1:0] out_word,
  output logic [(2*COORD_BITS+LEVEL_BITS+4)-1:0] out_word_two
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int L  = LEVEL_BITS;
  localparam int DW = $clog2(FRACTION_BITS);
  localparam logic [L-1:0] FULL = {L{1'b1}};

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  state_t               state, state_next;
  logic                 active, active_next;
  walr_pkg::line_case_t line_case, line_case_next;
  logic [C:0]           cur_x, cur_x_next;
  logic [C:0]           cur_y, cur_y_next;
  logic [C-1:0]         end_x, end_x_next;
  logic [C-1:0]         end_y, end_y_next;
  logic                 x_neg, x_neg_next;
  logic [C-1:0]         steps_left, steps_left_next;
  logic [F-1:0]         acc, acc_next;
  logic [F-1:0]         estep, estep_next;
  logic [C-1:0]         rem, rem_next;
  logic [C-1:0]         div_major, div_major_next;
  logic [DW-1:0]        div_cnt, div_cnt_next;

  logic [C:0]   x_stepped;
  logic [C:0]   y_inc;
  logic [F:0]   sum;
  logic         carry;
  logic [L-1:0] weight;
  logic [C:0]   gx;
  logic [C:0]   gy;
  logic [C+1:0] nb_x;
  logic [C:0]   nb_y;
  logic [C:0]   rem_sh;
  logic [C:0]   rem_sub;
  logic         div_bit;
  logic [C-1:0] steps_dec;

  // one step along the line
  always_comb begin
    x_stepped = x_neg ? (cur_x - (C+1)'(1)) : (cur_x + (C+1)'(1));
    y_inc     = cur_y + (C+1)'(1);
    steps_dec = steps_left - C'(1);
    sum       = {1'b0, acc} + {1'b0, estep};
    carry     = sum[F];
    weight    = sum[F-1 -: L];
    if (line_case == walr_pkg::CASE_YMAJ) begin
      gx   = carry ? x_stepped : cur_x;
      gy   = y_inc;
      nb_x = x_neg ? ({1'b0, gx} - (C+2)'(1)) : ({1'b0, gx} + (C+2)'(1));
      nb_y = gy;
    end else begin
      gx   = x_stepped;
      gy   = carry ? y_inc : cur_y;
      nb_x = {1'b0, gx};
      nb_y = gy + (C+1)'(1);
    end
  end

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem, 1'b0};
    rem_sub = rem_sh - {1'b0, div_major};
    div_bit = (rem_sh >= {1'b0, div_major});
  end

  // command execution
  always_comb begin
    state_next      = state;
    active_next     = active;
    line_case_next  = line_case;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    end_x_next      = end_x;
    end_y_next      = end_y;
    x_neg_next      = x_neg;
    steps_left_next = steps_left;
    acc_next        = acc;
    estep_next      = estep;
    rem_next        = rem;
    div_major_next  = div_major;
    div_cnt_next    = div_cnt;
    cmd_pop         = 1'b0;
    out_push        = 1'b0;
    out_push_two    = 1'b0;
    out_word        = '0;
    out_word_two    = '0;
    case (state)
      ST_RUN: begin
        if (cmd_valid && out_room_two) begin
          cmd_pop = 1'b1;
          if (cmd_ctrl.is_start) begin
            line_case_next  = cmd_ctrl.line_case;
            x_neg_next      = cmd_ctrl.x_neg;
            cur_x_next      = {1'b0, cmd_x0};
            cur_y_next      = {1'b0, cmd_y0};
            end_x_next      = cmd_x1;
            end_y_next      = cmd_y1;
            steps_left_next = cmd_steps;
            acc_next        = '0;
            estep_next      = '0;
            active_next     = !((cmd_ctrl.line_case == walr_pkg::CASE_HORIZ) &&
                                (cmd_steps == '0));
            out_push        = 1'b1;
            out_word        = {2'b00, cmd_x0, 1'b0, cmd_y0, FULL, !active_next};
            if ((cmd_ctrl.line_case == walr_pkg::CASE_YMAJ) ||
                (cmd_ctrl.line_case == walr_pkg::CASE_XMAJ)) begin
              state_next     = ST_DIV;
              rem_next       = cmd_minor;
              div_major_next = cmd_major;
              div_cnt_next   = DW'(F - 1);
            end
          end else if (active) begin
            if ((line_case == walr_pkg::CASE_HORIZ) ||
                (line_case == walr_pkg::CASE_VERT) ||
                (line_case == walr_pkg::CASE_DIAG)) begin
              // straight lines, one full pixel
              if (line_case != walr_pkg::CASE_VERT) begin
                cur_x_next = x_stepped;
              end
              if (line_case != walr_pkg::CASE_HORIZ) begin
                cur_y_next = y_inc;
              end
              steps_left_next = steps_dec;
              active_next     = (steps_dec != '0);
              out_push        = 1'b1;
              out_word        = {1'b0, cur_x_next, cur_y_next, FULL, !active_next};
            end else if (steps_left == '0) begin
              // endpoint closes the line
              active_next = 1'b0;
              out_push    = 1'b1;
              out_word    = {2'b00, end_x, 1'b0, end_y, FULL, 1'b1};
            end else begin
              // main pixel and neighbour
              acc_next        = sum[F-1:0];
              cur_x_next      = gx;
              cur_y_next      = gy;
              steps_left_next = steps_dec;
              out_push        = 1'b1;
              out_push_two    = 1'b1;
              out_word        = {1'b0, gx, gy, ~weight, 1'b0};
              out_word_two    = {nb_x, nb_y, weight, 1'b0};
            end
          end
        end
      end
      ST_DIV: begin
        rem_next   = div_bit ? rem_sub[C-1:0] : rem_sh[C-1:0];
        estep_next = {estep[F-2:0], div_bit};
        if (div_cnt == '0) begin
          state_next = ST_RUN;
        end else begin
          div_cnt_next = div_cnt - DW'(1);
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      active <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
    end
  end

  // line and division registers
  always_ff @(posedge clk) begin
    line_case  <= line_case_next;
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    end_x      <= end_x_next;
    end_y      <= end_y_next;
    x_neg      <= x_neg_next;
    steps_left <= steps_left_next;
    acc        <= acc_next;
    estep      <= estep_next;
    rem        <= rem_next;
    div_major  <= div_major_next;
    div_cnt    <= div_cnt_next;
  end

endmodule

`default_nettype wire

@@ sv/wu_antialiased_line_raster_top.sv @@
// wu_antialiased_line_raster_top: anti-aliased line rasteriser top level
// depends on walr_pkg, walr_front, walr_fifo and walr_back
//
//   channel   handshake            word
//   input     push / full          op, x_start, y_start, x_end, y_end
//   result    empty / pop          pixel_x, pixel_y, intensity, last
//
// a step word yields up to two result words in the back end
// a start word for a general line also runs the bit-serial
// divider; steps queued behind it wait for the divider
// first result word is registered in the command queue, then in the result queue
// reset clears the queues and ends any line; no clearing pass
// full rises when the four-word command queue fills; the back end stalls
// while the result queue has room for fewer than two words
`default_nettype none

module wu_antialiased_line_raster_top #(
  parameter int COORD_BITS    = 11,
  parameter int FRACTION_BITS = 16,
  parameter int LEVEL_BITS    = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         op,
  input  wire logic        [COORD_BITS-1:0] x_start,
  input  wire logic        [COORD_BITS-1:0] y_start,
  input  wire logic        [COORD_BITS-1:0] x_end,
  input  wire logic        [COORD_BITS-1:0] y_end,
  output logic                              empty,
  input  wire logic                         pop,
  output logic signed      [COORD_BITS+1:0] pixel_x,
  output logic             [COORD_BITS:0]   pixel_y,
  output logic             [LEVEL_BITS-1:0] intensity,
  output logic                              last
);

  localparam int C      = COORD_BITS;
  localparam int CTRL_W = $bits(walr_pkg::cmd_ctrl_t);
  localparam int CMD_W  = CTRL_W + 7 * C;
  localparam int OUT_W  = 2 * C + LEVEL_BITS + 4;

  walr_pkg::cmd_ctrl_t f_ctrl;
  logic [C-1:0] f_x0, f_y0, f_x1, f_y1, f_minor, f_major, f_steps;
  logic [CMD_W-1:0] f_word;

  logic [CMD_W-1:0] q_word;
  logic             q_empty;
  logic             q_room_two;
  walr_pkg::cmd_ctrl_t b_ctrl;
  logic [C-1:0] b_x0, b_y0, b_x1, b_y1, b_minor, b_major, b_steps;
  logic             cmd_pop;

  logic             out_push;
  logic             out_push_two;
  logic [OUT_W-1:0] out_word;
  logic [OUT_W-1:0] out_word_two;
  logic [OUT_W-1:0] head_word;
  logic             out_full;
  logic             out_room_two;

  // front: order and classify
  walr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .op      (op),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .ctrl    (f_ctrl),
    .x0      (f_x0),
    .y0      (f_y0),
    .x1      (f_x1),
    .y1      (f_y1),
    .minor   (f_minor),
    .major   (f_major),
    .steps   (f_steps)
  );

  assign f_word = {f_ctrl, f_x0, f_y0, f_x1, f_y1, f_minor, f_major, f_steps};

  // command queue between front and back
  walr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push && !full),
    .push_two  (1'b0),
    .wdata     (f_word),
    .wdata_two ('0),
    .pop       (cmd_pop),
    .rdata     (q_word),
    .empty     (q_empty),
    .full      (full),
    .room_two  (q_room_two)
  );

  assign {b_ctrl, b_x0, b_y0, b_x1, b_y1, b_minor, b_major, b_steps} = q_word;

  // back: line state and pixel stepping
  walr_back #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .LEVEL_BITS    (LEVEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_empty),
    .cmd_ctrl     (b_ctrl),
    .cmd_x0       (b_x0),
    .cmd_y0       (b_y0),
    .cmd_x1       (b_x1),
    .cmd_y1       (b_y1),
    .cmd_minor    (b_minor),
    .cmd_major    (b_major),
    .cmd_steps    (b_steps),
    .cmd_pop      (cmd_pop),
    .out_room_two (out_room_two),
    .out_push     (out_push),
    .out_push_two (out_push_two),
    .out_word     (out_word),
    .out_word_two (out_word_two)
  );

  // result queue; the back end writes its main word and, for a general line, a neighbour word too
  walr_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (4)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_two  (out_push_two),
    .wdata     (out_word),
    .wdata_two (out_word_two),
    .pop       (pop && !empty),
    .rdata     (head_word),
    .empty     (empty),
    .full      (out_full),
    .room_two  (out_room_two)
  );

  // result fields from the queue head; full queue shows as no room for two
  assign pixel_x   = $signed(head_word[OUT_W-1 -: C+2]);
  assign pixel_y   = head_word[LEVEL_BITS+C+1 -: C+1];
  assign intensity = out_full ? head_word[LEVEL_BITS:1] : head_word[LEVEL_BITS:1];
  assign last      = head_word[0];

endmodule

`default_nettype wire

@@ sv/walr_checker.sv @@
// walr_checker: port-level assertions on the rasteriser top level
// depends on wu_antialiased_line_raster_top; attached by the bind below
`default_nettype none

module walr_checker #(
  parameter int COORD_BITS = 11,
  parameter int LEVEL_BITS = 3
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         full,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic signed [COORD_BITS+1:0] pixel_x,
  input wire logic        [COORD_BITS:0]   pixel_y,
  input wire logic        [LEVEL_BITS-1:0] intensity,
  input wire logic                         last
);

  localparam logic signed [COORD_BITS+1:0] X_HI = {2'b01, {COORD_BITS{1'b0}}};
  localparam logic signed [COORD_BITS+1:0] X_LO = '1;
  localparam logic        [COORD_BITS:0]   Y_HI = {1'b1, {COORD_BITS{1'b0}}};

  // reset leaves both queues drained
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // a waiting result word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pixel_x) && $stable(pixel_y) &&
                       $stable(intensity) && $stable(last))
    else $error("result word changed while stalled");

  // the closing pixel of a line is always at full intensity
  a_last_full: assert property (@(posedge clk) disable iff (rst)
    !empty && last |-> intensity == {LEVEL_BITS{1'b1}})
    else $error("last pixel not at full intensity");

  // coordinates stay within one pixel of the raster
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pixel_x >= X_LO) && (pixel_x <= X_HI) && (pixel_y <= Y_HI))
    else $error("pixel coordinate out of range");

endmodule

bind wu_antialiased_line_raster_top walr_checker #(
  .COORD_BITS (COORD_BITS),
  .LEVEL_BITS (LEVEL_BITS)
) u_walr_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y),
  .intensity (intensity),
  .last      (last)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for the anti-aliased line rasteriser top level
// depends on walr_pkg and wu_antialiased_line_raster_top; holds its own pixel predictor
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_BITS    = 11;
  localparam int FRACTION_BITS = 16;
  localparam int LEVEL_BITS    = 3;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int STALL_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 24;
  localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = '1;

  typedef struct packed {
    logic [COORD_BITS+1:0] x;
    logic [COORD_BITS:0]   y;
    logic [LEVEL_BITS-1:0] level;
    logic                  last;
  } pixel_t;

  // pixel predictor and store of pixels still due from the block
  class pixel_scoreboard;
    pixel_t due_pixels[$];
    int mismatches = 0;

    bit                     drawing = 0;
    walr_pkg::line_case_t   kind = walr_pkg::CASE_HORIZ;
    bit [COORD_BITS:0]      pos_x = '0;
    bit [COORD_BITS:0]      pos_y = '0;
    bit [COORD_BITS-1:0]    stop_x = '0;
    bit [COORD_BITS-1:0]    stop_y = '0;
    bit                     x_back = 0;
    bit [COORD_BITS-1:0]    span_left = '0;
    bit [FRACTION_BITS-1:0] frac_acc = '0;
    bit [FRACTION_BITS-1:0] frac_step = '0;

    function int waiting();
      return due_pixels.size();
    endfunction

    function void emit(bit [COORD_BITS+1:0] x, bit [COORD_BITS:0] y,
                       bit [LEVEL_BITS-1:0] level, bit last);
      pixel_t p;
      p.x = x;
      p.y = y;
      p.level = level;
      p.last = last;
      due_pixels.push_back(p);
    endfunction

    function bit [COORD_BITS:0] next_x(bit [COORD_BITS:0] x);
      return x_back ? x - 1'b1 : x + 1'b1;
    endfunction

    // work out the pixels that one accepted input word gives
    function void note_word(bit opc, bit [COORD_BITS-1:0] xs, bit [COORD_BITS-1:0] ys,
                            bit [COORD_BITS-1:0] xe, bit [COORD_BITS-1:0] ye);
      bit [COORD_BITS-1:0] x0, y0, x1, y1, dx, dy;
      bit [COORD_BITS+FRACTION_BITS-1:0] num;
      bit [FRACTION_BITS:0] sum;
      bit [LEVEL_BITS-1:0] weight;
      bit lone;
      if (opc == walr_pkg::OP_START) begin
        x0 = xs; y0 = ys; x1 = xe; y1 = ye;
        // order endpoints by y, ties keep the given order
        if (y0 > y1) begin
          x0 = xe; y0 = ye; x1 = xs; y1 = ys;
        end
        pos_x = {1'b0, x0};
        pos_y = {1'b0, y0};
        stop_x = x1;
        stop_y = y1;
        x_back = x1 < x0;
        dx = x_back ? x0 - x1 : x1 - x0;
        dy = y1 - y0;
        frac_acc = '0;
        frac_step = '0;
        drawing = 1;
        if (dy == 0) begin
          kind = walr_pkg::CASE_HORIZ;
          span_left = dx;
        end else if (dx == 0) begin
          kind = walr_pkg::CASE_VERT;
          span_left = dy;
        end else if (dx == dy) begin
          kind = walr_pkg::CASE_DIAG;
          span_left = dy;
        end else if (dy > dx) begin
          kind = walr_pkg::CASE_YMAJ;
          span_left = dy - 1'b1;
          num = {dx, {FRACTION_BITS{1'b0}}};
          frac_step = FRACTION_BITS'(num / dy);
        end else begin
          kind = walr_pkg::CASE_XMAJ;
          span_left = dx - 1'b1;
          num = {dy, {FRACTION_BITS{1'b0}}};
          frac_step = FRACTION_BITS'(num / dx);
        end
        // a single point ends the line at once
        lone = (kind == walr_pkg::CASE_HORIZ) && (span_left == 0);
        if (lone) drawing = 0;
        emit({1'b0, pos_x}, pos_y, FULL_LEVEL, lone);
        return;
      end

      if (!drawing) return;

      // straight and diagonal lines: one full pixel per step
      if (kind == walr_pkg::CASE_HORIZ || kind == walr_pkg::CASE_VERT ||
          kind == walr_pkg::CASE_DIAG) begin
        if (kind != walr_pkg::CASE_VERT) pos_x = next_x(pos_x);
        if (kind != walr_pkg::CASE_HORIZ) pos_y = pos_y + 1'b1;
        span_left = span_left - 1'b1;
        if (span_left == 0) drawing = 0;
        emit({1'b0, pos_x}, pos_y, FULL_LEVEL, !drawing);
        return;
      end

      // general line: the stored endpoint closes it
      if (span_left == 0) begin
        drawing = 0;
        emit({2'b00, stop_x}, {1'b0, stop_y}, FULL_LEVEL, 1'b1);
        return;
      end

      // general line: carry out of the accumulator moves the minor axis
      sum = {1'b0, frac_acc} + {1'b0, frac_step};
      frac_acc = sum[FRACTION_BITS-1:0];
      if (kind == walr_pkg::CASE_YMAJ) begin
        if (sum[FRACTION_BITS]) pos_x = next_x(pos_x);
        pos_y = pos_y + 1'b1;
      end else begin
        if (sum[FRACTION_BITS]) pos_y = pos_y + 1'b1;
        pos_x = next_x(pos_x);
      end
      weight = frac_acc[FRACTION_BITS-1 -: LEVEL_BITS];
      span_left = span_left - 1'b1;
      emit({1'b0, pos_x}, pos_y, FULL_LEVEL - weight, 1'b0);
      if (kind == walr_pkg::CASE_YMAJ)
        emit(x_back ? {1'b0, pos_x} - 1'b1 : {1'b0, pos_x} + 1'b1, pos_y, weight, 1'b0);
      else
        emit({1'b0, pos_x}, pos_y + 1'b1, weight, 1'b0);
    endfunction

    // compare one accepted result word with the oldest pixel due
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel x=%0d y=%0d level=%0d last=%0b",
                   $signed(got.x), got.y, got.level, got.last);
        return;
      end
      want = due_pixels.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.level !== want.level ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"pixel mismatch: expected x=%0d y=%0d level=%0d last=%0b, ",
                    "got x=%0d y=%0d level=%0d last=%0b"},
                   $signed(want.x), want.y, want.level, want.last,
                   $signed(got.x), got.y, got.level, got.last);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          op = walr_pkg::OP_START;
  logic [COORD_BITS-1:0]         x_start = '0;
  logic [COORD_BITS-1:0]         y_start = '0;
  logic [COORD_BITS-1:0]         x_end = '0;
  logic [COORD_BITS-1:0]         y_end = '0;
  logic                          pop = 1'b0;
  logic                          full;
  logic                          empty;
  logic signed [COORD_BITS+1:0]  pixel_x;
  logic [COORD_BITS:0]           pixel_y;
  logic [LEVEL_BITS-1:0]         intensity;
  logic                          last;

  pixel_scoreboard sb = new();
  int send_idle = 0;
  int pop_stall = 0;
  int word_count = 0;
  int quiet_cycles = 0;

  wu_antialiased_line_raster_top #(
    .COORD_BITS(COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .LEVEL_BITS(LEVEL_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .op(op),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .empty(empty),
    .pop(pop),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .intensity(intensity),
    .last(last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: pop with random stalls
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall);
  end

  // monitor both channels on the values before the edge
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_word(op, x_start, y_start, x_end, y_end);
    if (!rst && pop && !empty) sb.check_pixel({pixel_x, pixel_y, intensity, last});
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("wu_antialiased_line_raster_top test failed");
      $finish;
    end
  end

  // offer one input word, return once it is accepted
  task automatic send_word(input logic opc, input int xs, input int ys,
                           input int xe, input int ye);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= opc;
    x_start <= COORD_BITS'(xs);
    y_start <= COORD_BITS'(ys);
    x_end <= COORD_BITS'(xe);
    y_end <= COORD_BITS'(ye);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // step words carry random, unused coordinates
  task automatic step_words(input int n);
    repeat (n)
      send_word(walr_pkg::OP_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
  endtask

  // hold off the sender until every pixel due has come out
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (sb.waiting() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // move away from base by offset, turning back at the edge of the field
  function automatic int near_coord(int base, int offset);
    if ($urandom_range(1))
      return (base + offset <= COORD_MAX) ? base + offset : base - offset;
    return (base - offset >= 0) ? base - offset : base + offset;
  endfunction

  // one line with random shape and content, mostly drawn to its end
  task automatic random_line();
    int x0, y0, x1, y1, reach, d, major, n, r;
    x0 = $urandom_range(COORD_MAX);
    y0 = $urandom_range(COORD_MAX);
    reach = ($urandom_range(9) == 0) ? 60 : 12;
    d = $urandom_range(1, reach);
    x1 = near_coord(x0, $urandom_range(reach));
    y1 = near_coord(y0, $urandom_range(reach));
    case ($urandom_range(9))
      0: y1 = y0;
      1: x1 = x0;
      2: begin
        x1 = near_coord(x0, d);
        y1 = near_coord(y0, d);
      end
      3: begin
        x1 = x0;
        y1 = y0;
      end
      4: begin
        x1 = $urandom_range(COORD_MAX);
        y1 = $urandom_range(COORD_MAX);
      end
      default: ;
    endcase
    major = (x1 > x0) ? x1 - x0 : x0 - x1;
    if (((y1 > y0) ? y1 - y0 : y0 - y1) > major) major = (y1 > y0) ? y1 - y0 : y0 - y1;
    n = major;
    r = $urandom_range(99);
    if (major > 60) n = $urandom_range(1, 40);
    else if (r < 12) n = $urandom_range(major);
    else if (r < 22) n = major + $urandom_range(1, 3);
    send_word(walr_pkg::OP_START, x0, y0, x1, y1);
    step_words(n);
    word_count += 1 + ((n < major) ? n : major);
  endtask

  // one phase of random lines and noise under the given idling
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_words);
    int target;
    send_idle = idle_pct;
    pop_stall = stall_pct;
    target = word_count + n_words;
    while (word_count < target) begin
      if ($urandom_range(99) < 90)
        random_line();
      else
        send_word(1'($urandom_range(1)), $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    end
    settle();
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle step, single points, each line kind at the field edges
    send_word(walr_pkg::OP_STEP, 0, 0, 0, 0);
    send_word(walr_pkg::OP_START, 0, 0, 0, 0);
    send_word(walr_pkg::OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(walr_pkg::OP_START, COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX);
    step_words(2);
    send_word(walr_pkg::OP_START, 0, COORD_MAX, 0, COORD_MAX - 2);
    step_words(2);
    send_word(walr_pkg::OP_START, COORD_MAX, 0, COORD_MAX - 2, 2);
    step_words(2);
    // y-major, neighbour to the right, then x-major with neighbour reaching y = 2047
    send_word(walr_pkg::OP_START, 0, 0, 1, 3);
    step_words(3);
    send_word(walr_pkg::OP_START, COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 2);
    step_words(3);
    // y-major leftwards, cut short by a new start
    send_word(walr_pkg::OP_START, 3, 0, 0, 7);
    step_words(3);
    send_word(walr_pkg::OP_START, 0, 0, COORD_MAX, 1000);
    settle();

    run_phase(0, 0, 210);
    run_phase(75, 0, 210);
    run_phase(0, 75, 210);
    run_phase(36, 36, 210);
    run_phase(0, 0, 210);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0)
      $display("wu_antialiased_line_raster_top test passed");
    else
      $display("wu_antialiased_line_raster_top test failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/walr_pkg.sv
sv/walr_fifo.sv
sv/walr_front.sv
sv/walr_back.sv
sv/wu_antialiased_line_raster_top.sv
sv/walr_checker.sv
tb/sv/testbench.sv
